FILE: rtl/core/tvkv_pkg.sv
// Shared types and constants for the time-versioned key/value lookup block.
`default_nettype none

package tvkv_pkg;

  // Width of a stored or queried timestamp.
  localparam int unsigned TS_W = 31;

  // Command codes carried on the input channel.
  localparam logic CMD_SET = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // Status codes returned on the result channel.
  typedef logic [1:0] status_t;
  localparam status_t STAT_STORED    = 2'd0;
  localparam status_t STAT_FOUND     = 2'd1;
  localparam status_t STAT_NOT_FOUND = 2'd2;
  localparam status_t STAT_FULL      = 2'd3;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PEND
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/tvkv_best.sv
// Best-match tracker: keeps the latest entry whose timestamp is the largest not above the query.
`default_nettype none

module tvkv_best
  import tvkv_pkg::*;
#(
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   clear,
  input  wire logic                   cand_vld,
  input  wire logic [KEY_WIDTH-1:0]   cand_key,
  input  wire logic [TS_W-1:0]        cand_ts,
  input  wire logic [VALUE_WIDTH-1:0] cand_value,
  input  wire logic [KEY_WIDTH-1:0]   q_key,
  input  wire logic [TS_W-1:0]        q_ts,
  output logic                        hit,
  output logic [VALUE_WIDTH-1:0]      best_value
);

  logic                   hit_r, hit_nxt;
  logic [TS_W-1:0]        best_ts_r, best_ts_nxt;
  logic [VALUE_WIDTH-1:0] best_val_r, best_val_nxt;
  logic                   take;

  // A candidate replaces the current best when its key matches, it is not
  // later than the query, and it is at least as late as the best so far.
  // Ties go to the later entry, as entries arrive in insertion order.
  always_comb begin
    take = cand_vld && (cand_key == q_key) && (cand_ts <= q_ts) &&
           (!hit_r || (cand_ts >= best_ts_r));
    hit_nxt      = hit_r;
    best_ts_nxt  = best_ts_r;
    best_val_nxt = best_val_r;
    if (clear) begin
      hit_nxt = 1'b0;
    end else if (take) begin
      hit_nxt      = 1'b1;
      best_ts_nxt  = cand_ts;
      best_val_nxt = cand_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
    best_ts_r  <= best_ts_nxt;
    best_val_r <= best_val_nxt;
  end

  assign hit        = hit_r;
  assign best_value = best_val_r;

endmodule

`default_nettype wire

FILE: rtl/core/time_versioned_key_value_lookup.sv
// Top level of the time-versioned key/value lookup table.
//
// An append-only table of (key, timestamp, value) entries held in one
// synchronous memory. Each input transaction on the in_ channel yields exactly
// one result transaction on the out_ channel, in order.
//   Set (in_command = 0): appends an entry and answers "stored", or answers
//     "table full" and drops the entry once DEPTH entries are held.
//   Get (in_command = 1): scans every stored entry, one memory read a cycle,
//     and answers "found" with the value of the matching key whose timestamp
//     is the largest not above the query (latest entry on a tie), or
//     "not found" with a zero value.
// A set, or a get on an empty table, needs no scan; any other get scans every
// stored entry before its result reaches the output register, as the scan
// is set by the single read port of the memory. Items are handled one at a
// time: no new transaction is accepted until the previous one has reached the
// output register. The output register lets a new transaction be accepted
// while the previous result waits; if the receiver stalls, the next result
// waits in a holding register and no further input is accepted until it
// moves on. Reset empties the table by clearing the entry count; memory
// contents are never cleared, as only entries below the count are read.
`default_nettype none

module time_versioned_key_value_lookup
  import tvkv_pkg::*;
#(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_command,
  input  wire logic [KEY_WIDTH-1:0]   in_key,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire logic [TS_W-1:0]        in_timestamp,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  out_status,
  output logic [VALUE_WIDTH-1:0]      out_result_value
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned EW = KEY_WIDTH + TS_W + VALUE_WIDTH;

  // Entry memory, one word per entry: {key, timestamp, value}.
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data_r;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          iss_r, iss_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [KEY_WIDTH-1:0]   q_key_r, q_key_nxt;
  logic [TS_W-1:0]        q_ts_r, q_ts_nxt;
  status_t                res_status_r, res_status_nxt;
  logic [VALUE_WIDTH-1:0] res_value_r, res_value_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [VALUE_WIDTH-1:0] out_value_r, out_value_nxt;

  logic                   in_acc;
  logic                   table_full;
  logic                   scan_issue;
  logic                   scan_done;
  logic                   out_free;
  logic                   mem_we;
  logic                   best_clear;
  logic                   best_hit;
  logic [VALUE_WIDTH-1:0] best_value;

  // Handshake and status terms shared by the control blocks.
  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign table_full = (count_r == CW'(DEPTH));
  assign scan_issue = (state_r == ST_SCAN) && (iss_r != count_r);
  assign scan_done  = (state_r == ST_SCAN) && (iss_r == count_r) && !rd_vld_r;
  assign out_free   = !out_valid_r || out_ready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if ((in_command == CMD_GET) && (count_r != '0)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_PEND;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_PEND;
        end
      end
      ST_PEND: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and output control.
  always_comb begin
    count_nxt      = count_r;
    iss_nxt        = iss_r;
    rd_vld_nxt     = scan_issue;
    q_key_nxt      = q_key_r;
    q_ts_nxt       = q_ts_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    mem_we         = 1'b0;
    best_clear     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_value_nxt = '0;
          if (in_command == CMD_SET) begin
            if (table_full) begin
              res_status_nxt = STAT_FULL;
            end else begin
              mem_we         = 1'b1;
              count_nxt      = count_r + CW'(1);
              res_status_nxt = STAT_STORED;
            end
          end else begin
            q_key_nxt      = in_key;
            q_ts_nxt       = in_timestamp;
            iss_nxt        = '0;
            best_clear     = 1'b1;
            res_status_nxt = STAT_NOT_FOUND;
          end
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          iss_nxt = iss_r + CW'(1);
        end
        if (scan_done) begin
          res_status_nxt = best_hit ? STAT_FOUND : STAT_NOT_FOUND;
          res_value_nxt  = best_hit ? best_value : '0;
        end
      end
      ST_PEND: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
        end
      end
      default: begin
        rd_vld_nxt = 1'b0;
      end
    endcase
  end

  // Entry memory: one write port for appends, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= {in_key, in_timestamp, in_value};
    end
    rd_data_r <= mem[iss_r[AW-1:0]];
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iss_r       <= iss_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_key_r      <= q_key_nxt;
    q_ts_r       <= q_ts_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  // Compare each entry read back against the query.
  tvkv_best #(
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_best (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (best_clear),
    .cand_vld  (rd_vld_r),
    .cand_key  (rd_data_r[EW-1 -: KEY_WIDTH]),
    .cand_ts   (rd_data_r[VALUE_WIDTH +: TS_W]),
    .cand_value(rd_data_r[VALUE_WIDTH-1:0]),
    .q_key     (q_key_r),
    .q_ts      (q_ts_r),
    .hit       (best_hit),
    .best_value(best_value)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

endmodule

`default_nettype wire
